@@ hw/rtl/bmp24g_pkg.sv @@
// ----------------------------------------------------------------------------
// bmp24g_pkg
// shared types and constants of the 24-bit bmp grayscale stream converter
// ----------------------------------------------------------------------------
`default_nettype none

package bmp24g_pkg;

   // header byte positions of the captured little-endian words
   localparam int unsigned OFFSET_FIRST = 10;
   localparam int unsigned OFFSET_LAST  = 13;
   localparam int unsigned WIDTH_FIRST  = 18;
   localparam int unsigned WIDTH_LAST   = 21;
   localparam int unsigned HEIGHT_FIRST = 22;
   localparam int unsigned HEIGHT_LAST  = 25;

   // smallest pixel data offset, so all captured bytes lie in the header
   localparam int unsigned MIN_OFFSET = 26;

   // divide by three: floor(x * 683 / 2048) is exact for x below 1024
   localparam int unsigned RECIP3_MUL   = 683;
   localparam int unsigned RECIP3_SHIFT = 11;

   // result queue: one entry per request that gives results
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // section codes of a result byte
   localparam logic [1:0] SEC_HEADER = 2'd0;
   localparam logic [1:0] SEC_GRAY   = 2'd1;
   localparam logic [1:0] SEC_PAD    = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_PIXEL  = 2'd1,
      PH_PAD    = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       new_file;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] section;
      logic       last_in_run;
   } rsp_type;

   // one queued entry: a gray entry stands for three results
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] section;
   } entry_type;

endpackage

`default_nettype wire

@@ hw/rtl/bmp24_grayscale_stream.sv @@
// ----------------------------------------------------------------------------
// bmp24_grayscale_stream
// converts a 24-bit bmp byte stream to grayscale, header and padding kept
// ----------------------------------------------------------------------------
// the results of a request pass through the registered result queue
// throughput: one request per cycle while the result queue is not full; a completed
//    pixel leaves the queue as three results, matching its three request bytes
// request side stalls only while the four-entry result queue is full
// reset clears all counters, captured words, phase and the result queue
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_grayscale_stream #(
   parameter int DIM_BITS = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   // request channel
   input  wire                    req_valid,
   output logic                   req_stall,
   input  bmp24g_pkg::req_type    req_data,
   // result channel
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output bmp24g_pkg::rsp_type    rsp_data
);

   localparam int PW = bmp24g_pkg::QUEUE_PTR_W;
   localparam int CW = bmp24g_pkg::QUEUE_CNT_W;

   localparam logic [DIM_BITS-1:0] DIM_MAX = '1;
   localparam logic [DIM_BITS-1:0] MIN_OFF = DIM_BITS'(bmp24g_pkg::MIN_OFFSET);
   localparam logic [DIM_BITS-1:0] P_OFF_LO = DIM_BITS'(bmp24g_pkg::OFFSET_FIRST);
   localparam logic [DIM_BITS-1:0] P_OFF_HI = DIM_BITS'(bmp24g_pkg::OFFSET_LAST);
   localparam logic [DIM_BITS-1:0] P_WID_LO = DIM_BITS'(bmp24g_pkg::WIDTH_FIRST);
   localparam logic [DIM_BITS-1:0] P_WID_HI = DIM_BITS'(bmp24g_pkg::WIDTH_LAST);
   localparam logic [DIM_BITS-1:0] P_HGT_LO = DIM_BITS'(bmp24g_pkg::HEIGHT_FIRST);
   localparam logic [DIM_BITS-1:0] P_HGT_HI = DIM_BITS'(bmp24g_pkg::HEIGHT_LAST);
   localparam logic [CW-1:0]       Q_FULL   = CW'(bmp24g_pkg::QUEUE_DEPTH);
   localparam logic [9:0]          RECIP3   = 10'(bmp24g_pkg::RECIP3_MUL);
   localparam int                  RSH      = bmp24g_pkg::RECIP3_SHIFT;

   // merge one byte of a little-endian word into the captured value, saturating
   function automatic logic [DIM_BITS-1:0] capture(input logic [DIM_BITS-1:0] old,
                                                   input logic [1:0] idx,
                                                   input logic [7:0] b);
      logic [4:0]          shift;
      logic [DIM_BITS+7:0] wide;
      shift = {idx, 3'b000};
      wide  = {8'd0, old} | ((DIM_BITS + 8)'(b) << shift);
      if (b == 8'd0) begin
         capture = old;
      end else if (int'(shift) >= DIM_BITS) begin
         capture = DIM_MAX;
      end else if (wide[DIM_BITS+7:DIM_BITS] != 8'd0) begin
         capture = DIM_MAX;
      end else begin
         capture = wide[DIM_BITS-1:0];
      end
   endfunction

   // ------------------------------------------------------------------------
   // stream state
   // ------------------------------------------------------------------------
   bmp24g_pkg::phase_type phase_ff, phase_in;
   logic [DIM_BITS-1:0]   pos_ff, pos_in;
   logic [DIM_BITS-1:0]   offset_ff, offset_in;
   logic [DIM_BITS-1:0]   width_ff, width_in;
   logic [DIM_BITS-1:0]   height_ff, height_in;
   logic [DIM_BITS-1:0]   col_ff, col_in;
   logic [DIM_BITS-1:0]   row_ff, row_in;
   logic [1:0]            comp_ff, comp_in;
   logic [9:0]            sum_ff, sum_in;
   logic [1:0]            pad_ff, pad_in;

   // state as seen by this request: a new file starts from reset values
   bmp24g_pkg::phase_type cur_phase;
   logic [DIM_BITS-1:0]   cur_pos, cur_offset, cur_width, cur_height, cur_col, cur_row;
   logic [1:0]            cur_comp, cur_pad;
   logic [9:0]            cur_sum;

   logic [7:0]            in_b;
   logic                  req_take;

   // shared intermediate values
   logic [9:0]            pix_sum;
   logic [19:0]           div_prod;
   logic [7:0]            gray;
   logic [1:0]            word_idx;
   logic [DIM_BITS-1:0]   off_new, wid_new, hgt_new, eff_off;
   logic [DIM_BITS-1:0]   col_next, row_next;
   logic [1:0]            pad_next;

   // result of this request
   logic                  gen_valid;
   bmp24g_pkg::entry_type gen_entry;

   assign in_b     = req_data.in_byte;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      if (req_data.new_file) begin
         cur_phase  = bmp24g_pkg::PH_HEADER;
         cur_pos    = '0;
         cur_offset = '0;
         cur_width  = '0;
         cur_height = '0;
         cur_col    = '0;
         cur_row    = '0;
         cur_comp   = 2'd0;
         cur_sum    = 10'd0;
         cur_pad    = 2'd0;
      end else begin
         cur_phase  = phase_ff;
         cur_pos    = pos_ff;
         cur_offset = offset_ff;
         cur_width  = width_ff;
         cur_height = height_ff;
         cur_col    = col_ff;
         cur_row    = row_ff;
         cur_comp   = comp_ff;
         cur_sum    = sum_ff;
         cur_pad    = pad_ff;
      end
   end

   // header capture: positions 10, 18 and 22 all have low bits 2'b10
   assign word_idx = cur_pos[1:0] - 2'd2;

   always_comb begin
      off_new = cur_offset;
      wid_new = cur_width;
      hgt_new = cur_height;
      if (cur_pos >= P_OFF_LO && cur_pos <= P_OFF_HI) begin
         off_new = capture(cur_offset, word_idx, in_b);
      end else if (cur_pos >= P_WID_LO && cur_pos <= P_WID_HI) begin
         wid_new = capture(cur_width, word_idx, in_b);
      end else if (cur_pos >= P_HGT_LO && cur_pos <= P_HGT_HI) begin
         hgt_new = capture(cur_height, word_idx, in_b);
      end
      eff_off = (off_new < MIN_OFF) ? MIN_OFF : off_new;
   end

   // pixel arithmetic: sum of three colour bytes, divided by three
   assign pix_sum  = cur_sum + 10'(in_b);
   assign div_prod = 20'(pix_sum) * 20'(RECIP3);
   assign gray     = div_prod[RSH+7:RSH];
   assign col_next = cur_col + 1'b1;
   assign row_next = cur_row + 1'b1;
   // padding (4 - 3w mod 4) mod 4 reduces to w mod 4
   assign pad_next = cur_pad - 2'd1;

   // next state
   always_comb begin
      phase_in  = cur_phase;
      pos_in    = cur_pos;
      offset_in = cur_offset;
      width_in  = cur_width;
      height_in = cur_height;
      col_in    = cur_col;
      row_in    = cur_row;
      comp_in   = cur_comp;
      sum_in    = cur_sum;
      pad_in    = cur_pad;
      unique case (cur_phase)
         bmp24g_pkg::PH_HEADER: begin
            offset_in = off_new;
            width_in  = wid_new;
            height_in = hgt_new;
            if (cur_pos != DIM_MAX) begin
               pos_in = cur_pos + 1'b1;
            end
            if (({1'b0, cur_pos} + 1'b1) >= {1'b0, eff_off}) begin
               col_in  = '0;
               row_in  = '0;
               comp_in = 2'd0;
               sum_in  = 10'd0;
               pad_in  = 2'd0;
               if (wid_new == '0 || hgt_new == '0) begin
                  phase_in = bmp24g_pkg::PH_DONE;
               end else begin
                  phase_in = bmp24g_pkg::PH_PIXEL;
               end
            end
         end
         bmp24g_pkg::PH_PIXEL: begin
            if (cur_comp < 2'd2) begin
               comp_in = cur_comp + 2'd1;
               sum_in  = pix_sum;
            end else begin
               comp_in = 2'd0;
               sum_in  = 10'd0;
               col_in  = col_next;
               if (col_next >= cur_width) begin
                  pad_in = cur_width[1:0];
                  if (cur_width[1:0] != 2'd0) begin
                     phase_in = bmp24g_pkg::PH_PAD;
                  end else begin
                     // row ends without padding
                     row_in   = row_next;
                     col_in   = '0;
                     phase_in = (row_next >= cur_height) ? bmp24g_pkg::PH_DONE
                                                         : bmp24g_pkg::PH_PIXEL;
                  end
               end
            end
         end
         bmp24g_pkg::PH_PAD: begin
            if (cur_pad != 2'd0) begin
               pad_in = pad_next;
            end
            if (cur_pad <= 2'd1) begin
               row_in   = row_next;
               col_in   = '0;
               phase_in = (row_next >= cur_height) ? bmp24g_pkg::PH_DONE
                                                   : bmp24g_pkg::PH_PIXEL;
            end
         end
         bmp24g_pkg::PH_DONE: begin
            // trailing bytes are dropped
         end
         default: begin
         end
      endcase
   end

   // results of this request
   always_comb begin
      gen_valid          = 1'b0;
      gen_entry.out_byte = in_b;
      gen_entry.section  = bmp24g_pkg::SEC_HEADER;
      unique case (cur_phase)
         bmp24g_pkg::PH_HEADER: begin
            gen_valid = 1'b1;
         end
         bmp24g_pkg::PH_PIXEL: begin
            gen_valid          = (cur_comp >= 2'd2);
            gen_entry.out_byte = gray;
            gen_entry.section  = bmp24g_pkg::SEC_GRAY;
         end
         bmp24g_pkg::PH_PAD: begin
            gen_valid         = 1'b1;
            gen_entry.section = bmp24g_pkg::SEC_PAD;
         end
         bmp24g_pkg::PH_DONE: begin
            gen_valid = 1'b0;
         end
         default: begin
            gen_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bmp24g_pkg::PH_HEADER;
         pos_ff    <= '0;
         offset_ff <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         comp_ff   <= 2'd0;
         sum_ff    <= 10'd0;
         pad_ff    <= 2'd0;
      end else if (req_take) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         offset_ff <= offset_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         comp_ff   <= comp_in;
         sum_ff    <= sum_in;
         pad_ff    <= pad_in;
      end
   end

   // ------------------------------------------------------------------------
   // result queue: one entry per request with results, a gray entry is
   // played out three times before it leaves
   // ------------------------------------------------------------------------
   bmp24g_pkg::entry_type queue_ff [bmp24g_pkg::QUEUE_DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [1:0]            rep_ff, rep_in;

   bmp24g_pkg::entry_type head;
   logic                  head_last;
   logic                  push;
   logic                  rsp_take;
   logic                  pop;

   assign req_stall = (count_ff == Q_FULL);
   assign push      = req_take && gen_valid;

   assign head      = queue_ff[rd_ptr_ff];
   assign head_last = (head.section != bmp24g_pkg::SEC_GRAY) || (rep_ff == 2'd2);
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign pop       = rsp_take && head_last;

   assign rsp_data.out_byte    = head.out_byte;
   assign rsp_data.section     = head.section;
   assign rsp_data.last_in_run = head_last;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
      if (pop) begin
         rep_in = 2'd0;
      end else if (rsp_take) begin
         rep_in = rep_ff + 2'd1;
      end else begin
         rep_in = rep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= gen_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         rep_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         rep_ff    <= rep_in;
      end
   end

endmodule

`default_nettype wire

@@ dv/bmp24g_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmp24g_checker
// watches both channels of the bmp grayscale converter, works out the bytes
// it should give for every accepted request and compares them in order
// ----------------------------------------------------------------------------

module bmp24g_checker
   import bmp24g_pkg::*;
#(
   parameter int DIM_BITS = 16
) (
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   input  wire             req_stall,
   input  req_type         req_data,
   input  wire             rsp_valid,
   input  wire             rsp_stall,
   input  rsp_type         rsp_data,
   output int unsigned     fail_count,
   output int unsigned     pending_results
);

   localparam logic [DIM_BITS-1:0] DIM_MAX = '1;
   localparam int unsigned REPORT_LIMIT = 10;

   rsp_type             expected_bytes[$];
   int unsigned         mismatch_total = 0;

   // converter state as the stream should leave it
   phase_type           stream_phase;
   logic [DIM_BITS-1:0] header_pos;
   logic [DIM_BITS-1:0] pixel_offset;
   logic [DIM_BITS-1:0] img_width;
   logic [DIM_BITS-1:0] img_height;
   logic [DIM_BITS-1:0] col;
   logic [DIM_BITS-1:0] row;
   logic [1:0]          colour_idx;
   logic [9:0]          colour_sum;
   logic [1:0]          pad_left;

   function automatic logic [DIM_BITS-1:0] captured_word(input logic [DIM_BITS-1:0] old,
                                                         input int unsigned byte_idx,
                                                         input logic [7:0] value);
      longint unsigned merged;
      if (value == 8'd0)
         return old;
      if (byte_idx * 8 >= DIM_BITS)
         return DIM_MAX;
      merged = longint'(old) | (longint'(value) << (byte_idx * 8));
      if (merged > 64'(DIM_MAX))
         return DIM_MAX;
      return merged[DIM_BITS-1:0];
   endfunction

   task automatic clear_image();
      col        = '0;
      row        = '0;
      colour_idx = '0;
      colour_sum = '0;
      pad_left   = '0;
   endtask

   task automatic clear_stream();
      clear_image();
      stream_phase = PH_HEADER;
      header_pos   = '0;
      pixel_offset = '0;
      img_width    = '0;
      img_height   = '0;
   endtask

   task automatic queue_result(input logic [7:0] value, input logic [1:0] sec,
                               input logic last);
      expected_bytes.push_back('{out_byte: value, section: sec, last_in_run: last});
   endtask

   task automatic finish_row();
      row = row + 1'b1;
      col = '0;
      if (row >= img_height)
         stream_phase = PH_DONE;
      else
         stream_phase = PH_PIXEL;
   endtask

   task automatic convert_byte(input req_type rq);
      int unsigned pos;
      int unsigned start_at;
      logic [7:0]  gray;
      if (rq.new_file)
         clear_stream();
      case (stream_phase)
         PH_HEADER: begin
            pos = 32'(header_pos);
            if (pos >= OFFSET_FIRST && pos <= OFFSET_LAST)
               pixel_offset = captured_word(pixel_offset, pos - OFFSET_FIRST, rq.in_byte);
            else if (pos >= WIDTH_FIRST && pos <= WIDTH_LAST)
               img_width = captured_word(img_width, pos - WIDTH_FIRST, rq.in_byte);
            else if (pos >= HEIGHT_FIRST && pos <= HEIGHT_LAST)
               img_height = captured_word(img_height, pos - HEIGHT_FIRST, rq.in_byte);
            if (header_pos != DIM_MAX)
               header_pos = header_pos + 1'b1;
            start_at = (32'(pixel_offset) < MIN_OFFSET) ? MIN_OFFSET : 32'(pixel_offset);
            if (pos + 1 >= start_at) begin
               clear_image();
               if (img_width == '0 || img_height == '0)
                  stream_phase = PH_DONE;
               else
                  stream_phase = PH_PIXEL;
            end
            queue_result(rq.in_byte, SEC_HEADER, 1'b1);
         end
         PH_PIXEL: begin
            colour_sum = colour_sum + 10'(rq.in_byte);
            if (colour_idx < 2'd2) begin
               colour_idx = colour_idx + 1'b1;
            end else begin
               gray = 8'(colour_sum / 10'd3);
               queue_result(gray, SEC_GRAY, 1'b0);
               queue_result(gray, SEC_GRAY, 1'b0);
               queue_result(gray, SEC_GRAY, 1'b1);
               colour_idx = '0;
               colour_sum = '0;
               col        = col + 1'b1;
               if (col >= img_width) begin
                  pad_left = 2'((4 - ((int'(img_width) * 3) % 4)) % 4);
                  if (pad_left != 2'd0)
                     stream_phase = PH_PAD;
                  else
                     finish_row();
               end
            end
         end
         PH_PAD: begin
            queue_result(rq.in_byte, SEC_PAD, 1'b1);
            if (pad_left != 2'd0)
               pad_left = pad_left - 1'b1;
            if (pad_left == 2'd0)
               finish_row();
         end
         default: ;
      endcase
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_bytes.size() == 0) begin
         mismatch_total++;
         if (mismatch_total <= REPORT_LIMIT)
            $display("%t unexpected result: byte %02h section %0d last %0b",
                     $time, got.out_byte, got.section, got.last_in_run);
         return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.section !== want.section ||
          got.last_in_run !== want.last_in_run) begin
         mismatch_total++;
         if (mismatch_total <= REPORT_LIMIT)
            $display("%t mismatch: expected %02h/%0d/%0b got %02h/%0d/%0b",
                     $time, want.out_byte, want.section, want.last_in_run,
                     got.out_byte, got.section, got.last_in_run);
      end
   endtask

   // results are handled before the request of the same edge, which can
   // only produce its bytes from the next cycle on
   always @(posedge clock) begin
      if (reset) begin
         clear_stream();
         expected_bytes.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result(rsp_data);
         if (req_valid && !req_stall)
            convert_byte(req_data);
      end
      fail_count      <= mismatch_total;
      pending_results <= expected_bytes.size();
   end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives bmp files, well-formed and broken, through the grayscale converter
// with random gaps and stalls; a checker beside the block judges every byte
// ----------------------------------------------------------------------------

module testbench;
   import bmp24g_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned RANDOM_ITEMS   = 380;

   // kinds of random file, taken in turn so each one shows up
   localparam int unsigned KIND_PLAIN     = 0;
   localparam int unsigned KIND_PADDING   = 1;
   localparam int unsigned KIND_EMPTY     = 2;
   localparam int unsigned KIND_SATURATED = 3;
   localparam int unsigned KIND_NOISE     = 4;
   localparam int unsigned FILE_KINDS     = KIND_NOISE + 1;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;

   int unsigned fail_count;
   int unsigned pending_results;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned items_sent    = 0;

   // bytes of the file being built
   logic [7:0]  file_bytes[$];

   bmp24_grayscale_stream #(
      .DIM_BITS (16)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   bmp24g_checker #(
      .DIM_BITS (16)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: stall at random at the current rate
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog: too long without any handshake on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request; valid stays up into the next request unless a gap is drawn
   task automatic send_byte(input logic [7:0] value, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: value, new_file: first};
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // hold the request side quiet until every expected byte has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
   endtask

   task automatic send_file(input logic fresh);
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], fresh && (i == 0));
   endtask

   // random header of hdr_len bytes with the three words laid in little-endian
   task automatic make_header(input logic [31:0] offset_word, input logic [31:0] width_word,
                              input logic [31:0] height_word, input int unsigned hdr_len);
      file_bytes.delete();
      for (int i = 0; i < hdr_len; i++)
         file_bytes.push_back(8'($urandom_range(255)));
      for (int k = 0; k < 4; k++) begin
         file_bytes[OFFSET_FIRST + k] = offset_word[8*k +: 8];
         file_bytes[WIDTH_FIRST + k]  = width_word[8*k +: 8];
         file_bytes[HEIGHT_FIRST + k] = height_word[8*k +: 8];
      end
   endtask

   // whole rows of random pixels, each followed by its padding
   task automatic add_rows(input int unsigned width, input int unsigned rows);
      int unsigned pad;
      pad = (4 - ((width * 3) % 4)) % 4;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < width * 3; c++)
            file_bytes.push_back(8'($urandom_range(255)));
         for (int p = 0; p < pad; p++)
            file_bytes.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic add_bytes(input int unsigned count);
      for (int i = 0; i < count; i++)
         file_bytes.push_back(8'($urandom_range(255)));
   endtask

   // offset: mostly a real one past the header, sometimes a short one
   function automatic int unsigned pick_offset();
      if ($urandom_range(3) == 0)
         return $urandom_range(MIN_OFFSET - 1);
      return MIN_OFFSET + $urandom_range(14);
   endfunction

   function automatic int unsigned header_length(input int unsigned offset_word);
      return (offset_word < MIN_OFFSET) ? MIN_OFFSET : offset_word;
   endfunction

   // build and send one random file of the given kind
   task automatic run_file(input int unsigned kind);
      int unsigned off;
      int unsigned w;
      int unsigned h;
      int unsigned body;
      logic [31:0] big;
      case (kind)
         KIND_PLAIN: begin
            off = pick_offset();
            w   = $urandom_range(1, 6);
            h   = $urandom_range(1, 3);
            make_header(off, w, h, header_length(off));
            add_rows(w, h);
            items_sent += file_bytes.size();
            // bytes past the last row are swallowed
            add_bytes($urandom_range(3));
            send_file(1'b1);
         end
         KIND_PADDING: begin
            w = $urandom_range(1, 4);
            h = $urandom_range(2, 4);
            make_header(MIN_OFFSET, w, h, MIN_OFFSET);
            add_rows(w, h);
            items_sent += file_bytes.size();
            send_file(1'b1);
         end
         KIND_EMPTY: begin
            off = MIN_OFFSET + $urandom_range(4);
            if ($urandom_range(1) == 0) begin
               w = 0;
               h = $urandom_range(1, 300);
            end else begin
               w = $urandom_range(1, 300);
               h = 0;
            end
            make_header(off, w, h, off);
            items_sent += file_bytes.size();
            add_bytes($urandom_range(1, 6));
            send_file(1'b1);
         end
         KIND_SATURATED: begin
            // a word with a byte above the dimension width clamps to all ones;
            // the image is cut short by the next file
            big = 32'($urandom_range(1, 255)) << (16 + 8 * $urandom_range(1));
            if ($urandom_range(1) == 0) begin
               w = $urandom_range(1, 3);
               make_header(MIN_OFFSET, w, big | 32'($urandom_range(255)), MIN_OFFSET);
               add_rows(w, 2);
            end else begin
               make_header(MIN_OFFSET, big | 32'($urandom_range(255)),
                           $urandom_range(1, 2), MIN_OFFSET);
               add_bytes($urandom_range(3, 15));
            end
            items_sent += file_bytes.size();
            send_file(1'b1);
         end
         default: begin
            // random bytes with new_file dropping in anywhere
            body = $urandom_range(1, 30);
            for (int i = 0; i < body; i++)
               send_byte(8'($urandom_range(255)), (i == 0) || ($urandom_range(15) == 0));
            items_sent += body;
         end
      endcase
   endtask

   initial begin
      int unsigned file_idx;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed file straight after reset without new_file: short offset,
      // one white pixel giving the top gray value, one padding byte, then
      // trailing bytes that must vanish
      make_header(32'd0, 32'd1, 32'd1, MIN_OFFSET);
      file_bytes[0] = 8'h00;
      file_bytes[1] = 8'hff;
      file_bytes.push_back(8'hff);
      file_bytes.push_back(8'hff);
      file_bytes.push_back(8'hff);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h5a);
      file_bytes.push_back(8'ha5);
      send_file(1'b0);
      drain_results();

      // random files in three idling regimes
      file_idx = 0;
      for (int stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (items_sent < RANDOM_ITEMS * (stage + 1) / 3) begin
            run_file(file_idx % FILE_KINDS);
            file_idx++;
         end
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
